>>> src/dspc_pkg.sv
// ----------------------------------------------------------------------------
// dspc_pkg
// Shared types, codes and helpers for the display sleep power controller.
// ----------------------------------------------------------------------------
package dspc_pkg;

   // power states
   localparam logic [1:0] ST_ACTIVE   = 2'd0;
   localparam logic [1:0] ST_DIMMING  = 2'd1;
   localparam logic [1:0] ST_SLEEPING = 2'd2;
   localparam logic [1:0] ST_WAKING   = 2'd3;

   // event opcodes
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_ACTIVITY = 3'd1;
   localparam logic [2:0] OP_MESSAGE  = 3'd2;
   localparam logic [2:0] OP_ACCEL    = 3'd3;
   localparam logic [2:0] OP_SLEEP    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_CTRL_ENABLE   = 3'd0;
   localparam logic [2:0] REG_MOTION_WAKE   = 3'd1;
   localparam logic [2:0] REG_MESSAGE_WAKE  = 3'd2;
   localparam logic [2:0] REG_DIM_TIMEOUT   = 3'd3;
   localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_WAKE_COOLDOWN = 3'd5;
   localparam logic [2:0] REG_MOTION_LOW    = 3'd6;
   localparam logic [2:0] REG_MOTION_HIGH   = 3'd7;

   // register reset values
   localparam logic [30:0] DIM_TIMEOUT_RST   = 31'd120000;
   localparam logic [30:0] SLEEP_TIMEOUT_RST = 31'd180000;
   localparam logic [30:0] WAKE_COOLDOWN_RST = 31'd2000;
   localparam logic [31:0] MOTION_LOW_RST    = 32'd9314704;
   localparam logic [31:0] MOTION_HIGH_RST   = 32'd26419600;

   localparam logic [31:0] TICK_MIN_MS = 32'd100;

   // panel and imu commands
   localparam logic [1:0] PANEL_NONE = 2'd0;
   localparam logic [1:0] PANEL_ON   = 2'd1;
   localparam logic [1:0] PANEL_OFF  = 2'd2;
   localparam logic [1:0] IMU_NONE   = 2'd0;
   localparam logic [1:0] IMU_LOW    = 2'd1;
   localparam logic [1:0] IMU_NORMAL = 2'd2;

   // brightness targets and fade times
   localparam logic [1:0] BRIGHT_OFF = 2'd0;
   localparam logic [1:0] BRIGHT_LOW = 2'd1;
   localparam logic [1:0] BRIGHT_MID = 2'd2;
   localparam logic [1:0] BRIGHT_MAX = 2'd3;
   localparam logic [9:0] FADE_ACTIVE   = 10'd200;
   localparam logic [9:0] FADE_DIMMING  = 10'd500;
   localparam logic [9:0] FADE_SLEEPING = 10'd1000;
   localparam logic [9:0] FADE_WAKING   = 10'd300;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        now_ms;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [1:0] entered_state;
      logic [1:0] brightness_level;
      logic [9:0] fade_time_ms;
      logic [1:0] panel_cmd;
      logic [1:0] imu_cmd;
      logic       last;
   } rsp_type;

   // signed 32-bit difference now - then is non-negative and reached limit
   function automatic logic elapsed(input logic [31:0] now, input logic [31:0] then_ms,
                                    input logic [30:0] limit);
      logic [31:0] d;
      d = now - then_ms;
      return !d[31] && (d[30:0] >= limit);
   endfunction

   // result of moving from one state to another; last is set by the caller
   function automatic rsp_type make_rsp(input logic [1:0] from_st, input logic [1:0] to_st,
                                        input logic imu_leave, input logic motion_en);
      rsp_type r;
      r.entered_state = to_st;
      r.panel_cmd = (from_st == ST_SLEEPING) ? PANEL_ON : PANEL_NONE;
      r.imu_cmd   = IMU_NONE;
      r.last      = 1'b0;
      case (to_st)
         ST_ACTIVE: begin
            r.brightness_level = BRIGHT_MAX;
            r.fade_time_ms     = FADE_ACTIVE;
         end
         ST_DIMMING: begin
            r.brightness_level = BRIGHT_LOW;
            r.fade_time_ms     = FADE_DIMMING;
         end
         ST_SLEEPING: begin
            r.brightness_level = BRIGHT_OFF;
            r.fade_time_ms     = FADE_SLEEPING;
            r.panel_cmd        = PANEL_OFF;
            if (motion_en) r.imu_cmd = IMU_LOW;
         end
         default: begin
            r.brightness_level = BRIGHT_MID;
            r.fade_time_ms     = FADE_WAKING;
         end
      endcase
      if (imu_leave && motion_en) r.imu_cmd = IMU_NORMAL;
      return r;
   endfunction

endpackage

>>> src/display_sleep_power_controller.sv
// ----------------------------------------------------------------------------
// display_sleep_power_controller
// Four-state display power controller driven by timestamped events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event transaction (tick, user activity, message, accel
//   sample, manual sleep) with a millisecond timestamp. Only ticks (at most
//   one per 100 ms) and manual sleep change the power state; other events
//   latch flags or times that the next tick consumes.
//   rsp_* carries one transaction per state change: brightness target, fade
//   time, panel and IMU commands. An event yields zero, one or two of them;
//   last marks the final one of an event.
//   csr_* writes a register; write only while idle.
// Flow: an event is registered on acceptance (accel squares are formed
//   there) and processed once the result queue has room; its results enter
//   the queue at the end of that cycle, and rsp_valid follows the registered count.
// Throughput: one event per cycle. The processing stage needs room for two
//   results in the 4-entry result queue, so the rate drops only when the
//   receiver lags behind a burst of state changes.
// Reset: synchronous, active high; state ACTIVE, times and flags zero,
//   registers to their defaults, queue empty.
// Stall: a stalled receiver fills the result queue; req_ready then drops
//   until entries drain. Nothing is dropped.
module display_sleep_power_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dspc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dspc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [31:0]       csr_wdata
);
   import dspc_pkg::*;

   // configuration registers
   logic        ctrl_enable_ff;
   logic        motion_wake_ff;
   logic        message_wake_ff;
   logic [30:0] dim_timeout_ff;
   logic [30:0] sleep_timeout_ff;
   logic [30:0] wake_cooldown_ff;
   logic [31:0] motion_low_ff;
   logic [31:0] motion_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_enable_ff   <= 1'b1;
         motion_wake_ff   <= 1'b1;
         message_wake_ff  <= 1'b1;
         dim_timeout_ff   <= DIM_TIMEOUT_RST;
         sleep_timeout_ff <= SLEEP_TIMEOUT_RST;
         wake_cooldown_ff <= WAKE_COOLDOWN_RST;
         motion_low_ff    <= MOTION_LOW_RST;
         motion_high_ff   <= MOTION_HIGH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_CTRL_ENABLE:   ctrl_enable_ff   <= csr_wdata[0];
            REG_MOTION_WAKE:   motion_wake_ff   <= csr_wdata[0];
            REG_MESSAGE_WAKE:  message_wake_ff  <= csr_wdata[0];
            REG_DIM_TIMEOUT:   dim_timeout_ff   <= csr_wdata[30:0];
            REG_SLEEP_TIMEOUT: sleep_timeout_ff <= csr_wdata[30:0];
            REG_WAKE_COOLDOWN: wake_cooldown_ff <= csr_wdata[30:0];
            REG_MOTION_LOW:    motion_low_ff    <= csr_wdata;
            REG_MOTION_HIGH:   motion_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage: event plus per-axis squares
   logic        s1_valid_ff;
   logic [2:0]  s1_op_ff;
   logic [31:0] s1_now_ff;
   logic [30:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [30:0] prod_x, prod_y, prod_z;
   logic        proc_fire;
   logic        room;

   // a square of a 16-bit signed value is at most 2^30
   assign prod_x    = 31'(req_data.accel_x * req_data.accel_x);
   assign prod_y    = 31'(req_data.accel_y * req_data.accel_y);
   assign prod_z    = 31'(req_data.accel_z * req_data.accel_z);
   assign req_ready = !s1_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_op_ff  <= req_data.opcode;
         s1_now_ff <= req_data.now_ms;
         sq_x_ff   <= prod_x;
         sq_y_ff   <= prod_y;
         sq_z_ff   <= prod_z;
      end
   end

   // controller state
   logic [1:0]  power_state_ff, power_state_in;
   logic [31:0] last_act_ff, last_act_in;
   logic [31:0] wake_time_ff, wake_time_in;
   logic [31:0] last_tick_ff, last_tick_in;
   logic        act_flag_ff, act_flag_in;
   logic        mot_flag_ff, mot_flag_in;
   logic        msg_flag_ff, msg_flag_in;

   // event evaluation
   logic [31:0] sq_sum;
   logic [31:0] tick_gap;
   logic        is_motion;
   logic        act_tr, mot_tr, msg_tr;
   logic [1:0]  st_a, st_b, st_c, to_st;
   logic [31:0] wake_c;
   logic        to_hit;
   rsp_type     flag_rsp, to_rsp;
   rsp_type     ent0, ent1;
   logic [1:0]  push_n;

   assign sq_sum    = {1'b0, sq_x_ff} + {1'b0, sq_y_ff} + {1'b0, sq_z_ff};
   assign is_motion = (sq_sum < motion_low_ff) || (sq_sum > motion_high_ff);
   assign tick_gap  = s1_now_ff - last_tick_ff;

   // tick sequence: activity, motion, message, then one timeout
   always_comb begin
      act_tr = act_flag_ff && (power_state_ff != ST_ACTIVE);
      st_a   = act_tr ? ST_ACTIVE : power_state_ff;
      mot_tr = mot_flag_ff && (st_a == ST_SLEEPING);
      st_b   = mot_tr ? ST_WAKING : st_a;
      msg_tr = msg_flag_ff && message_wake_ff && (st_b == ST_SLEEPING);
      st_c   = msg_tr ? ST_WAKING : st_b;
      wake_c = (mot_tr || msg_tr) ? s1_now_ff : wake_time_ff;
      to_st  = ST_SLEEPING;
      case (st_c)
         ST_ACTIVE: begin
            to_hit = elapsed(s1_now_ff, last_act_ff, dim_timeout_ff);
            to_st  = ST_DIMMING;
         end
         ST_DIMMING:  to_hit = elapsed(s1_now_ff, last_act_ff, sleep_timeout_ff);
         ST_WAKING:   to_hit = elapsed(s1_now_ff, wake_c, wake_cooldown_ff);
         default:     to_hit = 1'b0;
      endcase
      flag_rsp = make_rsp(power_state_ff, st_c, act_tr, motion_wake_ff);
      to_rsp   = make_rsp(st_c, to_st, 1'b0, motion_wake_ff);
   end

   always_comb begin
      power_state_in = power_state_ff;
      last_act_in    = last_act_ff;
      wake_time_in   = wake_time_ff;
      last_tick_in   = last_tick_ff;
      act_flag_in    = act_flag_ff;
      mot_flag_in    = mot_flag_ff;
      msg_flag_in    = msg_flag_ff;
      ent0           = to_rsp;
      ent1           = to_rsp;
      push_n         = 2'd0;
      if (proc_fire && ctrl_enable_ff) begin
         case (s1_op_ff)
            OP_TICK: begin
               if (tick_gap >= TICK_MIN_MS) begin
                  last_tick_in = s1_now_ff;
                  act_flag_in  = 1'b0;
                  mot_flag_in  = 1'b0;
                  msg_flag_in  = 1'b0;
                  wake_time_in = wake_c;
                  // at most one flag transition, then at most one timeout
                  if (act_tr || mot_tr || msg_tr) begin
                     ent0   = flag_rsp;
                     push_n = to_hit ? 2'd2 : 2'd1;
                  end else begin
                     push_n = to_hit ? 2'd1 : 2'd0;
                  end
                  power_state_in = to_hit ? to_st : st_c;
               end
            end
            OP_ACTIVITY: begin
               last_act_in = s1_now_ff;
               if (power_state_ff != ST_ACTIVE) act_flag_in = 1'b1;
            end
            OP_MESSAGE: begin
               if (message_wake_ff && power_state_ff == ST_SLEEPING) msg_flag_in = 1'b1;
            end
            OP_ACCEL: begin
               if (motion_wake_ff && is_motion &&
                   (power_state_ff == ST_SLEEPING || power_state_ff == ST_WAKING)) begin
                  mot_flag_in = 1'b1;
               end
            end
            OP_SLEEP: begin
               if (power_state_ff != ST_SLEEPING) begin
                  ent0           = make_rsp(power_state_ff, ST_SLEEPING, 1'b0, motion_wake_ff);
                  push_n         = 2'd1;
                  power_state_in = ST_SLEEPING;
               end
            end
            default: ;
         endcase
      end
      // final result of this event
      if (push_n == 2'd1) ent0.last = 1'b1;
      ent1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_state_ff <= ST_ACTIVE;
         last_act_ff    <= '0;
         wake_time_ff   <= '0;
         last_tick_ff   <= '0;
         act_flag_ff    <= 1'b0;
         mot_flag_ff    <= 1'b0;
         msg_flag_ff    <= 1'b0;
      end else begin
         power_state_ff <= power_state_in;
         last_act_ff    <= last_act_in;
         wake_time_ff   <= wake_time_in;
         last_tick_ff   <= last_tick_in;
         act_flag_ff    <= act_flag_in;
         mot_flag_ff    <= mot_flag_in;
         msg_flag_ff    <= msg_flag_in;
      end
   end

   // result queue
   rsp_type          fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign room      = count_ff <= CNT_W'(FIFO_DEPTH - 2);
   assign proc_fire = s1_valid_ff && room;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = fifo_mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_mem[wr_ptr_ff] <= ent0;
      if (push_n == 2'd2) fifo_mem[wr_ptr_ff + PTR_W'(1)] <= ent1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue count over depth");

   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && !ctrl_enable_ff) |-> push_n == 2'd0)
      else $error("result produced while disabled");

   a_change_reported: assert property (@(posedge clock) disable iff (reset)
      (power_state_in != power_state_ff) |-> push_n != 2'd0)
      else $error("state change without result");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !proc_fire |=> $stable(power_state_ff))
      else $error("state moved without an event");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |=> rsp_valid)
      else $error("pushed result not presented");
`endif

endmodule
